FILE: rtl/core/sha1_stream_hasher_unit_assert.svh
// Assertion macros for the SHA-1 hasher controller.
`ifndef SHA1_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA1_STREAM_HASHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHA1SH_CHECK_NOW(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sha1sh: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SHA1SH_CHECK_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sha1sh: next-cycle check failed");

`endif

FILE: rtl/core/sha1sh_pkg.sv
package sha1sh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSRC_DATA,
        BSRC_PAD,
        BSRC_ZERO,
        BSRC_LEN
    } byte_src_t;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_A,
        PH_MAJORITY,
        PH_PARITY_B
    } phase_t;

    localparam logic [6:0]  ROUND_LAST     = 7'd79;
    localparam logic [6:0]  PHASE_B_START  = 7'd20;
    localparam logic [6:0]  PHASE_C_START  = 7'd40;
    localparam logic [6:0]  PHASE_D_START  = 7'd60;
    localparam logic [5:0]  POS_LAST       = 6'd63;
    localparam logic [5:0]  POS_LEN        = 6'd56;
    localparam logic [2:0]  DIGEST_LAST    = 3'd4;
    localparam logic [7:0]  PAD_BYTE       = 8'h80;
    localparam logic [63:0] LEN_STEP       = 64'd8;

    typedef struct packed {
        logic      byte_wr;
        byte_src_t byte_src;
        logic      len_add;
        logic      load;
        logic      round;
        phase_t    phase;
        logic      add;
        logic      restart;
        logic [2:0] out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } dp_status_t;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = 32'h67452301;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input phase_t ph);
        logic [31:0] k;
        unique case (ph)
            PH_CHOOSE:   k = 32'h5A827999;
            PH_PARITY_A: k = 32'h6ED9EBA1;
            PH_MAJORITY: k = 32'h8F1BBCDC;
            PH_PARITY_B: k = 32'hCA62C1D6;
            default:     k = 32'h5A827999;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/core/sha1_stream_hasher_unit.sv
// Channel    | Dir | Handshake              | Payload (lowest bit first)
// s_axis     | in  | s_axis_tvalid/tready   | tdata: data_byte; tuser: byte_present;
//            |     |                        | tlast: final_item
// m_axis     | out | m_axis_tvalid/tready   | tdata: digest_word; tuser: word_index;
//            |     |                        | tlast: last_word
//
// A word that does not complete a 64-byte block is taken without a compression.
// A word that completes a block starts a compression: one load, 80 rounds of the
// single round unit, one chaining add. A final word then pads the block byte by
// byte (up to 72 bytes, one or two more compressions) and emits five digest words,
// one per cycle while m_axis_tready is high.
// Reset loads the initial vector and clears the bit count and byte position;
// the block buffer holds no reset. s_axis_tready drops during compression,
// padding and digest output; a low m_axis_tready holds the current word.
module sha1_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha1sh_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence loads, rounds, padding and digest output.
    sha1sh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser),
        .in_final   (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_index  (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .status     (status),
        .cmd        (cmd)
    );

    // Hold the block, schedule, working and chaining words, and the bit count.
    sha1sh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .digest_word (m_axis_tdata)
    );

endmodule

FILE: rtl/core/sha1sh_datapath.sv
module sha1sh_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             data_byte,
    input  sha1sh_pkg::dp_cmd_t    cmd,
    output sha1sh_pkg::dp_status_t status,
    output logic [31:0]            digest_word
);
    import sha1sh_pkg::*;

    logic [31:0] sched_reg [16];
    logic [31:0] work_reg [5];
    logic [31:0] chain_reg [5];
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;

    logic [7:0]  byte_val;
    logic [63:0] len_shifted;
    logic [31:0] w_mix;
    logic [31:0] w_next;
    logic [31:0] f_val;
    logic [31:0] tmp_val;
    logic [31:0] a_w, b_w, c_w, d_w, e_w;

    assign status.pos = pos_reg;

    // Length bytes go out most significant first: byte i sits at bit (7 - i) * 8.
    assign len_shifted = len_reg >> {~pos_reg[2:0], 3'b000};

    always_comb
    begin
        unique case (cmd.byte_src)
            BSRC_DATA: byte_val = data_byte;
            BSRC_PAD:  byte_val = PAD_BYTE;
            BSRC_ZERO: byte_val = 8'h00;
            BSRC_LEN:  byte_val = len_shifted[7:0];
            default:   byte_val = 8'h00;
        endcase
    end

    assign a_w = work_reg[0];
    assign b_w = work_reg[1];
    assign c_w = work_reg[2];
    assign d_w = work_reg[3];
    assign e_w = work_reg[4];

    // Sliding schedule window: entry 0 is w[t], entry 15 receives w[t+16].
    assign w_mix  = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_next = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        unique case (cmd.phase)
            PH_CHOOSE:   f_val = (b_w & c_w) | (~b_w & d_w);
            PH_MAJORITY: f_val = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
            PH_PARITY_A,
            PH_PARITY_B: f_val = b_w ^ c_w ^ d_w;
            default:     f_val = b_w ^ c_w ^ d_w;
        endcase
    end

    assign tmp_val = {a_w[26:0], a_w[31:27]} + f_val + e_w
                     + round_const(cmd.phase) + sched_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w_next;
        end
        else if (cmd.byte_wr)
        begin
            unique case (pos_reg[1:0])
                2'd0:    sched_reg[pos_reg[5:2]][31:24] <= byte_val;
                2'd1:    sched_reg[pos_reg[5:2]][23:16] <= byte_val;
                2'd2:    sched_reg[pos_reg[5:2]][15:8]  <= byte_val;
                2'd3:    sched_reg[pos_reg[5:2]][7:0]   <= byte_val;
                default: sched_reg[pos_reg[5:2]][7:0]   <= byte_val;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 5; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_reg[0] <= tmp_val;
            work_reg[1] <= a_w;
            work_reg[2] <= {b_w[1:0], b_w[31:2]};
            work_reg[3] <= c_w;
            work_reg[4] <= d_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= init_word(3'(i));
            end
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= init_word(3'(i));
            end
        end
        else if (cmd.add)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    always_comb
    begin
        len_next = len_reg;
        pos_next = pos_reg;
        if (cmd.restart)
        begin
            len_next = '0;
            pos_next = '0;
        end
        else
        begin
            if (cmd.len_add)
            begin
                len_next = len_reg + LEN_STEP;
            end
            if (cmd.byte_wr)
            begin
                pos_next = pos_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        unique case (cmd.out_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            3'd4:    digest_word = chain_reg[4];
            default: digest_word = chain_reg[0];
        endcase
    end

endmodule

FILE: rtl/core/sha1sh_ctrl.sv
`include "sha1_stream_hasher_unit_assert.svh"

module sha1sh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_present,
    input  logic                   in_final,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_index,
    output logic                   out_last,
    input  sha1sh_pkg::dp_status_t status,
    output sha1sh_pkg::dp_cmd_t    cmd
);
    import sha1sh_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    state_t     resume_reg;
    state_t     resume_next;
    logic [6:0] round_reg;
    logic [6:0] round_next;
    logic [2:0] out_idx_reg;
    logic [2:0] out_idx_next;

    always_comb
    begin
        state_next   = state_reg;
        resume_next  = resume_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_present && status.pos == POS_LAST)
                    begin
                        state_next  = ST_LOAD;
                        resume_next = in_final ? ST_PAD : ST_IDLE;
                    end
                    else if (in_final)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = resume_reg;
            end
            ST_PAD:
            begin
                if (status.pos == POS_LAST)
                begin
                    state_next  = ST_LOAD;
                    resume_next = ST_ZERO;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (status.pos == POS_LEN)
                begin
                    state_next = ST_LEN;
                end
                else if (status.pos == POS_LAST)
                begin
                    state_next  = ST_LOAD;
                    resume_next = ST_ZERO;
                end
            end
            ST_LEN:
            begin
                if (status.pos == POS_LAST)
                begin
                    state_next  = ST_LOAD;
                    resume_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (out_idx_reg == DIGEST_LAST)
                    begin
                        out_idx_next = '0;
                        resume_next  = ST_IDLE;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        out_index = out_idx_reg;
        out_last  = (out_idx_reg == DIGEST_LAST);

        cmd          = '0;
        cmd.byte_src = BSRC_DATA;
        cmd.out_idx  = out_idx_reg;
        priority if (round_reg < PHASE_B_START)
        begin
            cmd.phase = PH_CHOOSE;
        end
        else if (round_reg < PHASE_C_START)
        begin
            cmd.phase = PH_PARITY_A;
        end
        else if (round_reg < PHASE_D_START)
        begin
            cmd.phase = PH_MAJORITY;
        end
        else
        begin
            cmd.phase = PH_PARITY_B;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.byte_wr = in_valid && in_present;
                cmd.len_add = in_valid && in_present;
            end
            ST_LOAD:  cmd.load = 1'b1;
            ST_ROUND: cmd.round = 1'b1;
            ST_ADD:   cmd.add = 1'b1;
            ST_PAD:
            begin
                cmd.byte_wr  = 1'b1;
                cmd.byte_src = BSRC_PAD;
            end
            ST_ZERO:
            begin
                cmd.byte_wr  = (status.pos != POS_LEN);
                cmd.byte_src = BSRC_ZERO;
            end
            ST_LEN:
            begin
                cmd.byte_wr  = 1'b1;
                cmd.byte_src = BSRC_LEN;
            end
            ST_OUT:   cmd.restart = out_ready && (out_idx_reg == DIGEST_LAST);
            default:  cmd.restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            resume_reg  <= ST_IDLE;
            round_reg   <= '0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            resume_reg  <= resume_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
        end
    end

    `SHA1SH_CHECK_NOW(a_ready_excludes_valid, clk, rst_n, in_ready, !out_valid)
    `SHA1SH_CHECK_NEXT(a_rounds_run_on, clk, rst_n, (state_reg == ST_ROUND) && (round_reg != ROUND_LAST), state_reg == ST_ROUND)
    `SHA1SH_CHECK_NOW(a_len_in_tail, clk, rst_n, state_reg == ST_LEN, status.pos[5:3] == 3'b111)
    `SHA1SH_CHECK_NOW(a_digest_on_block_edge, clk, rst_n, (state_reg == ST_ADD) && (resume_reg == ST_OUT), status.pos == POS_LAST + 6'd1)
    `SHA1SH_CHECK_NEXT(a_digest_done, clk, rst_n, out_valid && out_ready && out_last, (state_reg == ST_IDLE) && (out_idx_reg == 3'd0))

endmodule

FILE: tb/tb_sha1_stream_hasher_unit.sv
`timescale 1ns / 1ps

module tb_sha1_stream_hasher_unit;

    // SHA-1 initial chaining vector and round constants
    localparam logic [31:0] IV_H0 = 32'h67452301;
    localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_H2 = 32'h98BADCFE;
    localparam logic [31:0] IV_H3 = 32'h10325476;
    localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
    localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_FIELD_POS = 6'd56;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

    // Digest of the zero-length message, h0 in the top bits
    localparam logic [159:0] EMPTY_DIGEST =
        160'hDA39A3EE_5E6B4B0D_3255BFEF_95601890_AFD80709;

    localparam int RANDOM_ITEMS   = 270;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // One input word: a message byte plus its two flags
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       fin;
    } in_word_t;

    // One digest word as it leaves the block
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    // Directed row: typed digest only where it is known by heart
    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         fin;
        logic         typed;
        logic [159:0] digest;
    } dir_row_t;

    localparam int DIR_COUNT = 12;
    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},         // empty word, nothing happens
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message right after reset
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},         // lone zero byte carrying the end mark
        '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, 160'h0},         // empty word inside a message
        '{8'h00, 1'b0, 1'b1, 1'b0, 160'h0},         // end mark without a byte
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b0, 160'h0},         // "abc"
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // chaining words back at the IV
        '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}    // data bits ignored without a byte
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Hash model state
    logic [31:0] blk_w [16];
    logic [31:0] chain_h [5];
    logic [63:0] msg_bits;
    logic [5:0]  fill_pos;

    digest_word_t expected_words [$];

    int  mismatches;
    int  words_checked;
    int  items_sent;
    int  bytes_sent;
    int  empty_words;
    int  digests_queued;
    int  idle_cycles;
    bit  sender_fast;
    bit  rx_fast;
    bit  hold_req;
    bit  hold_taken;

    sha1_stream_hasher_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Restore the chaining words to the IV and start an empty block
    function automatic void sha1_restart();
        chain_h[0] = IV_H0;
        chain_h[1] = IV_H1;
        chain_h[2] = IV_H2;
        chain_h[3] = IV_H3;
        chain_h[4] = IV_H4;
        msg_bits = '0;
        fill_pos = '0;
    endfunction

    // Run 80 rounds over the buffered block and fold into the chain
    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        for (int i = 0; i < 16; i++)
            w[i] = blk_w[i];
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wt = w[r];
            else
            begin
                // Expand the schedule in place, 16-entry ring
                wt = rotl32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                            w[(r + 2) % 16] ^ w[r % 16], 1);
                w[r % 16] = wt;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CHOOSE;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_PARITY_A;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJORITY;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_PARITY_B;
            end
            sum = rotl32(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Place one byte big-endian into the block; compress when it fills
    function automatic void sha1_absorb(input logic [7:0] v);
        int lane;
        lane = 3 - fill_pos[1:0];
        blk_w[fill_pos[5:2]][lane * 8 +: 8] = v;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0)
            sha1_compress();
    endfunction

    // Take one accepted input word; return 1 with the digest on an end mark
    function automatic bit sha1_take_word(input in_word_t wd, output logic [159:0] dg);
        logic [63:0] len;
        dg = '0;
        if (wd.present)
        begin
            sha1_absorb(wd.data);
            msg_bits += 64'd8;
        end
        if (!wd.fin)
            return 1'b0;
        len = msg_bits;
        sha1_absorb(PAD_MARK);
        // Zero fill wraps into a fresh block when the length does not fit
        while (fill_pos != LEN_FIELD_POS)
            sha1_absorb(8'h00);
        for (int i = 0; i < 8; i++)
            sha1_absorb(len[63 - 8 * i -: 8]);
        dg = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
        sha1_restart();
        return 1'b1;
    endfunction

    // Compare a digest word against the oldest pending one
    function automatic void check_digest_word(input logic [31:0] w, input logic [2:0] idx,
                                              input logic last);
        digest_word_t ew;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] unexpected digest word %08h idx %0d last %0b",
                         $realtime, w, idx, last);
            return;
        end
        ew = expected_words.pop_front();
        words_checked++;
        if (w !== ew.word || idx !== ew.idx || last !== ew.last)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] digest word mismatch: exp %08h idx %0d last %0b, got %08h idx %0d last %0b",
                         $realtime, ew.word, ew.idx, ew.last, w, idx, last);
        end
    endfunction

    // Offer one word after a random gap and hold it until accepted.
    // Keep tvalid high straight into the next word when the gap is zero.
    task automatic send_word(input in_word_t wd, input bit typed, input logic [159:0] typed_dg);
        int gap;
        logic [159:0] dg;
        digest_word_t ew;
        gap = sender_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= wd.data;
        s_axis_tuser  <= wd.present;
        s_axis_tlast  <= wd.fin;
        do @(posedge clk); while (!s_axis_tready);
        if (wd.present || wd.fin)
            items_sent++;
        else
            empty_words++;
        if (wd.present)
            bytes_sent++;
        if (sha1_take_word(wd, dg))
        begin
            if (typed)
                dg = typed_dg;
            for (int i = 0; i < 5; i++)
            begin
                ew.word = dg[159 - 32 * i -: 32];
                ew.idx  = 3'(i);
                ew.last = (3'(i) == LAST_WORD_IDX);
                expected_words = {expected_words, ew};
            end
            digests_queued++;
        end
    endtask

    // Drop tvalid and hold off until every pending digest word has drained
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    // Receiver: random ready gaps, one long hold when asked
    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        rx_fast = 1'b0;
        hold_taken = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                // Stall the output long enough that the block backs up its input
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_fast ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            check_digest_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (m_axis_tlast)
                rx_fast = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: count cycles in which no word moves on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no word moved for %0d cycles, %0d digest words pending",
                             idle_cycles, expected_words.size());
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Main stimulus
    initial
    begin
        in_word_t wd;
        int len;
        int msg_no;
        bit end_on_byte;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        mismatches    = 0;
        words_checked = 0;
        items_sent    = 0;
        bytes_sent    = 0;
        empty_words   = 0;
        digests_queued = 0;
        sender_fast   = 1'b0;
        hold_req      = 1'b0;
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;
        sha1_restart();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: edge bytes, empty words, empty and short messages
        for (int r = 0; r < DIR_COUNT; r++)
        begin
            wd.data    = DIR_ROWS[r].data;
            wd.present = DIR_ROWS[r].present;
            wd.fin     = DIR_ROWS[r].fin;
            send_word(wd, DIR_ROWS[r].typed, DIR_ROWS[r].digest);
        end

        // Sender pause: let everything drain before the random part
        drain_pause();

        // Random messages. Open with a pad-overflow length and an exact-fit
        // length; ask the receiver to hold during the first digest so the
        // second message backs up against the stalled output.
        hold_req = 1'b1;
        items_sent = 0;
        msg_no = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            sender_fast = ($urandom_range(0, 3) == 0);
            if (msg_no == 0)
                len = 56;
            else if (msg_no == 1)
                len = 55;
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(57, 70);
            else
                len = $urandom_range(0, 12);
            end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            if (msg_no == 6)
                drain_pause();
            for (int n = 0; n < len; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Empty word with random data bits, ignored by the block
                    wd.data    = 8'($urandom_range(0, 255));
                    wd.present = 1'b0;
                    wd.fin     = 1'b0;
                    send_word(wd, 1'b0, '0);
                end
                wd.data    = 8'($urandom_range(0, 255));
                wd.present = 1'b1;
                wd.fin     = end_on_byte && (n == len - 1);
                send_word(wd, 1'b0, '0);
            end
            if (!end_on_byte)
            begin
                wd.data    = 8'($urandom_range(0, 255));
                wd.present = 1'b0;
                wd.fin     = 1'b1;
                send_word(wd, 1'b0, '0);
            end
            msg_no++;
        end

        // Wait out the pending digests, then the block's own tail
        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages, %0d bytes, %0d ignored empty words; %0d digest words checked.",
                 digests_queued, bytes_sent, empty_words, words_checked);
        $display("Run included empty, one-byte, exact-fit and pad-overflow messages, a long output hold and drain pauses.");
        if (expected_words.size() != 0)
            $display("%0d digest words never arrived", expected_words.size());
        if (mismatches == 0 && expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/sha1sh_pkg.sv
rtl/core/sha1sh_datapath.sv
rtl/core/sha1sh_ctrl.sv
rtl/core/sha1_stream_hasher_unit.sv
tb/tb_sha1_stream_hasher_unit.sv
